[rtl/tgq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch gesture qualifier package
// Shared widths, codes, register defaults and state types for the qualifier.
// ----------------------------------------------------------------------------
package tgq_pkg;

   localparam int RAW_W      = 12;
   localparam int TIME_W     = 32;
   localparam int DLY_W      = 16;
   localparam int CANVAS_X_W = 9;
   localparam int CANVAS_Y_W = 8;
   localparam int GEST_W     = 2;

   localparam int CANVAS_WIDTH_DEF  = 320;
   localparam int CANVAS_HEIGHT_DEF = 240;

   localparam logic [RAW_W-1:0] RAW_RAIL = 12'hFFF;

   localparam int REQ_TDATA_W = 72;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 48;
   localparam int RSP_TUSER_W = 2;
   localparam int RSP_PAD_W   = RSP_TDATA_W - CANVAS_X_W - CANVAS_Y_W - 2 * RAW_W;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAL_X_LOW       = 4'd0,
      CSR_CAL_X_HIGH      = 4'd1,
      CSR_CAL_Y_LOW       = 4'd2,
      CSR_CAL_Y_HIGH      = 4'd3,
      CSR_LONG_PRESS_TIME = 4'd4,
      CSR_RELEASE_TIME    = 4'd5,
      CSR_TAP_DEBOUNCE    = 4'd6,
      CSR_PRESSURE_LIMIT  = 4'd7
   } csr_index_type;

   localparam logic [RAW_W-1:0] CAL_LOW_RST        = 12'd200;
   localparam logic [RAW_W-1:0] CAL_HIGH_RST       = 12'd3900;
   localparam logic [DLY_W-1:0] LONG_PRESS_RST     = 16'd1000;
   localparam logic [DLY_W-1:0] RELEASE_RST        = 16'd100;
   localparam logic [DLY_W-1:0] TAP_DEBOUNCE_RST   = 16'd300;
   localparam logic [RAW_W-1:0] PRESSURE_LIMIT_RST = 12'd4095;

   typedef enum logic [GEST_W-1:0] {
      GEST_NONE = 2'd0,
      GEST_TAP  = 2'd1,
      GEST_LONG = 2'd2
   } gesture_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MAP,
      ST_SEND
   } state_type;

endpackage

[rtl/tgq_serial_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring unsigned division, one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
module tgq_serial_div #(
   parameter int NUM_W = 21,
   parameter int DEN_W = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   trial_sub;
   logic             fits;

   // The dividend shifts out of the top of the quotient register while the
   // quotient bits shift in at the bottom.
   always_comb begin
      trial     = {rem_ff, quo_ff[NUM_W-1]};
      trial_sub = trial - {1'b0, den_ff};
      fits      = (trial >= {1'b0, den_ff});
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         den_in = divisor;
         cnt_in = CNT_W'(NUM_W);
      end else if (cnt_ff != '0) begin
         quo_in  = {quo_ff[NUM_W-2:0], fits};
         rem_in  = fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/tgq_coord_map.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coordinate mapper
// Clamps a raw reading to the calibration bounds and scales it to the canvas.
// ----------------------------------------------------------------------------
module tgq_coord_map #(
   parameter int SIZE  = tgq_pkg::CANVAS_WIDTH_DEF,
   parameter int OUT_W = tgq_pkg::CANVAS_X_W
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [tgq_pkg::RAW_W-1:0] raw,
   input  logic [tgq_pkg::RAW_W-1:0] lo,
   input  logic [tgq_pkg::RAW_W-1:0] hi,
   output logic                     done,
   output logic [OUT_W-1:0]          coord
);

   localparam int RAW_W = tgq_pkg::RAW_W;
   localparam int Q_W   = $clog2(SIZE);
   localparam int NUM_W = RAW_W + Q_W;
   localparam logic [NUM_W-1:0] SPAN = NUM_W'(SIZE - 1);

   logic [RAW_W-1:0] clamped;
   logic [RAW_W-1:0] diff_ff, diff_in;
   logic [RAW_W-1:0] den_ff, den_in;
   logic             eq_ff, eq_in;
   logic             rev_ff, rev_in;
   logic             mul_go_ff;
   logic             done_ff, done_in;
   logic [OUT_W-1:0] coord_ff, coord_in;
   logic [NUM_W-1:0] product;
   logic             div_start;
   logic             div_done;
   logic [NUM_W-1:0] div_quo;

   // With the bounds reversed the result is the last canvas position without any
   // division, whatever value the clamp gives.
   always_comb begin
      if (raw < lo) begin
         clamped = lo;
      end else if (raw > hi) begin
         clamped = hi;
      end else begin
         clamped = raw;
      end
      diff_in = clamped - lo;
      den_in  = hi - lo;
      eq_in   = (hi == lo);
      rev_in  = (hi < lo);
   end

   assign product   = {{Q_W{1'b0}}, diff_ff} * SPAN;
   assign div_start = mul_go_ff && !eq_ff && !rev_ff;

   tgq_serial_div #(
      .NUM_W (NUM_W),
      .DEN_W (RAW_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      coord_in = coord_ff;
      done_in  = 1'b0;
      if (mul_go_ff && eq_ff) begin
         coord_in = '0;
         done_in  = 1'b1;
      end else if (mul_go_ff && rev_ff) begin
         coord_in = OUT_W'(SPAN);
         done_in  = 1'b1;
      end else if (div_done) begin
         coord_in = OUT_W'(div_quo);
         done_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_go_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         mul_go_ff <= start;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         diff_ff <= diff_in;
         den_ff  <= den_in;
         eq_ff   <= eq_in;
         rev_ff  <= rev_in;
      end
      coord_ff <= coord_in;
   end

   assign done  = done_ff;
   assign coord = coord_ff;

endmodule

[rtl/touch_gesture_qualifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch gesture qualifier
// Qualifies touch polls into tap and long-press events with press location.
// ----------------------------------------------------------------------------
// Sequence: an accepted poll is evaluated, then its result is loaded into the
// result register. A poll that starts a press first waits on the coordinate
// mappers, whose bit-serial dividers run unless the bounds are equal or reversed.
// Throughput: one poll at a time; the next is accepted once the result is out.
// Reset is synchronous and active high; it restores the register defaults and
// clears the press state and latched start point to zero.
module touch_gesture_qualifier #(
   parameter int CANVAS_WIDTH  = tgq_pkg::CANVAS_WIDTH_DEF,
   parameter int CANVAS_HEIGHT = tgq_pkg::CANVAS_HEIGHT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Poll request stream.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // raw_x [11:0], raw_y [23:12], pressure [35:24], now_ms [67:36], zero pad.
   input  logic [tgq_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // enabled [0], contact [1].
   input  logic [tgq_pkg::REQ_TUSER_W-1:0]   req_tuser,
   // Result stream.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // canvas_x [8:0], canvas_y [16:9], press_raw_x [28:17], press_raw_y [40:29],
   // zero pad.
   output logic [tgq_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // gesture [1:0].
   output logic [tgq_pkg::RSP_TUSER_W-1:0]   rsp_tuser,
   // Register write port.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tgq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tgq_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int RAW_W  = tgq_pkg::RAW_W;
   localparam int TIME_W = tgq_pkg::TIME_W;
   localparam int DLY_W  = tgq_pkg::DLY_W;
   localparam int CX_W   = tgq_pkg::CANVAS_X_W;
   localparam int CY_W   = tgq_pkg::CANVAS_Y_W;

   // Configuration registers.
   logic [RAW_W-1:0] cal_x_low_ff, cal_x_high_ff, cal_y_low_ff, cal_y_high_ff;
   logic [DLY_W-1:0] long_press_ff, release_ff, debounce_ff;
   logic [RAW_W-1:0] pressure_limit_ff;

   // Captured request.
   logic              in_enabled_ff, in_contact_ff;
   logic [RAW_W-1:0]  in_raw_x_ff, in_raw_y_ff, in_pressure_ff;
   logic [TIME_W-1:0] in_now_ff;

   // Press tracking state.
   logic              finger_down_ff, finger_down_in;
   logic              long_done_ff, long_done_in;
   logic [TIME_W-1:0] press_start_ff, press_start_in;
   logic [TIME_W-1:0] last_contact_ff, last_contact_in;
   logic [TIME_W-1:0] last_tap_ff, last_tap_in;
   logic [RAW_W-1:0]  start_raw_x_ff, start_raw_x_in;
   logic [RAW_W-1:0]  start_raw_y_ff, start_raw_y_in;
   logic [CX_W-1:0]   start_canvas_x_ff;
   logic [CY_W-1:0]   start_canvas_y_ff;
   tgq_pkg::gesture_type gesture_ff, gesture_in;
   logic              press_edge;

   // Sequencer.
   tgq_pkg::state_type state_ff, state_in;
   logic              accept;
   logic              eval_en;
   logic              map_start;
   logic              out_free;
   logic              out_load;
   logic              x_done, y_done;
   logic              x_done_ff, y_done_ff;
   logic              maps_done;
   logic [CX_W-1:0]   map_x;
   logic [CY_W-1:0]   map_y;

   // Result register.
   logic                              rsp_valid_ff;
   logic [tgq_pkg::RSP_TDATA_W-1:0]   rsp_data_ff;
   logic [tgq_pkg::GEST_W-1:0]        rsp_gest_ff;

   // Qualification terms.
   logic              read_ok;
   logic              contact_ok;
   logic [TIME_W-1:0] since_press, since_contact, since_tap;
   logic              long_due;

   // ------------------------------------------------------------------------
   // The block takes every register write unchecked; software must only write while idle.
   // ------------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_x_low_ff      <= tgq_pkg::CAL_LOW_RST;
         cal_x_high_ff     <= tgq_pkg::CAL_HIGH_RST;
         cal_y_low_ff      <= tgq_pkg::CAL_LOW_RST;
         cal_y_high_ff     <= tgq_pkg::CAL_HIGH_RST;
         long_press_ff     <= tgq_pkg::LONG_PRESS_RST;
         release_ff        <= tgq_pkg::RELEASE_RST;
         debounce_ff       <= tgq_pkg::TAP_DEBOUNCE_RST;
         pressure_limit_ff <= tgq_pkg::PRESSURE_LIMIT_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            tgq_pkg::CSR_CAL_X_LOW:       cal_x_low_ff      <= csr_data[RAW_W-1:0];
            tgq_pkg::CSR_CAL_X_HIGH:      cal_x_high_ff     <= csr_data[RAW_W-1:0];
            tgq_pkg::CSR_CAL_Y_LOW:       cal_y_low_ff      <= csr_data[RAW_W-1:0];
            tgq_pkg::CSR_CAL_Y_HIGH:      cal_y_high_ff     <= csr_data[RAW_W-1:0];
            tgq_pkg::CSR_LONG_PRESS_TIME: long_press_ff     <= csr_data;
            tgq_pkg::CSR_RELEASE_TIME:    release_ff        <= csr_data;
            tgq_pkg::CSR_TAP_DEBOUNCE:    debounce_ff       <= csr_data;
            tgq_pkg::CSR_PRESSURE_LIMIT:  pressure_limit_ff <= csr_data[RAW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Request capture.
   // ------------------------------------------------------------------------
   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (accept) begin
         in_enabled_ff  <= req_tuser[0];
         in_contact_ff  <= req_tuser[1];
         in_raw_x_ff    <= req_tdata[11:0];
         in_raw_y_ff    <= req_tdata[23:12];
         in_pressure_ff <= req_tdata[35:24];
         in_now_ff      <= req_tdata[67:36];
      end
   end

   // ------------------------------------------------------------------------
   // Gesture decision, evaluated in the cycle after a request is taken.
   // A read is implausible when the pressure reaches the limit, both coordinates are
   // zero, or either coordinate sits on the rail; such a contact counts as no
   // contact.
   // ------------------------------------------------------------------------
   always_comb begin
      read_ok = (in_pressure_ff < pressure_limit_ff)
             && !((in_raw_x_ff == '0) && (in_raw_y_ff == '0))
             && (in_raw_x_ff != tgq_pkg::RAW_RAIL)
             && (in_raw_y_ff != tgq_pkg::RAW_RAIL);
      contact_ok    = in_contact_ff && read_ok;
      since_press   = in_now_ff - press_start_ff;
      since_contact = in_now_ff - last_contact_ff;
      since_tap     = in_now_ff - last_tap_ff;
      // On the press edge the hold time is zero, so only a zero limit fires.
      if (finger_down_ff) begin
         long_due = !long_done_ff && (since_press >= TIME_W'(long_press_ff));
      end else begin
         long_due = (long_press_ff == '0);
      end

      finger_down_in  = finger_down_ff;
      long_done_in    = long_done_ff;
      press_start_in  = press_start_ff;
      last_contact_in = last_contact_ff;
      last_tap_in     = last_tap_ff;
      start_raw_x_in  = start_raw_x_ff;
      start_raw_y_in  = start_raw_y_ff;
      gesture_in      = tgq_pkg::GEST_NONE;
      press_edge      = 1'b0;

      if (!in_enabled_ff) begin
         finger_down_in = 1'b0;
      end else if (contact_ok) begin
         last_contact_in = in_now_ff;
         long_done_in    = finger_down_ff ? long_done_ff : 1'b0;
         if (!finger_down_ff) begin
            finger_down_in = 1'b1;
            press_start_in = in_now_ff;
            start_raw_x_in = in_raw_x_ff;
            start_raw_y_in = in_raw_y_ff;
            press_edge     = 1'b1;
         end
         if (long_due) begin
            long_done_in = 1'b1;
            gesture_in   = tgq_pkg::GEST_LONG;
         end
      end else if (finger_down_ff && (since_contact >= TIME_W'(release_ff))) begin
         // Contact has been gone long enough: the press is over.
         finger_down_in = 1'b0;
         if (!long_done_ff && (since_tap >= TIME_W'(debounce_ff))) begin
            last_tap_in = in_now_ff;
            gesture_in  = tgq_pkg::GEST_TAP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         finger_down_ff  <= 1'b0;
         long_done_ff    <= 1'b0;
         press_start_ff  <= '0;
         last_contact_ff <= '0;
         last_tap_ff     <= '0;
         start_raw_x_ff  <= '0;
         start_raw_y_ff  <= '0;
         gesture_ff      <= tgq_pkg::GEST_NONE;
      end else if (eval_en) begin
         finger_down_ff  <= finger_down_in;
         long_done_ff    <= long_done_in;
         press_start_ff  <= press_start_in;
         last_contact_ff <= last_contact_in;
         last_tap_ff     <= last_tap_in;
         start_raw_x_ff  <= start_raw_x_in;
         start_raw_y_ff  <= start_raw_y_in;
         gesture_ff      <= gesture_in;
      end
   end

   // ------------------------------------------------------------------------
   // Coordinate mapping on the press edge. Both axes run side by side, each
   // through its own bit-serial divider.
   // ------------------------------------------------------------------------
   tgq_coord_map #(
      .SIZE  (CANVAS_WIDTH),
      .OUT_W (CX_W)
   ) u_map_x (
      .clock (clock),
      .reset (reset),
      .start (map_start),
      .raw   (in_raw_x_ff),
      .lo    (cal_x_low_ff),
      .hi    (cal_x_high_ff),
      .done  (x_done),
      .coord (map_x)
   );

   tgq_coord_map #(
      .SIZE  (CANVAS_HEIGHT),
      .OUT_W (CY_W)
   ) u_map_y (
      .clock (clock),
      .reset (reset),
      .start (map_start),
      .raw   (in_raw_y_ff),
      .lo    (cal_y_low_ff),
      .hi    (cal_y_high_ff),
      .done  (y_done),
      .coord (map_y)
   );

   assign maps_done = (x_done_ff || x_done) && (y_done_ff || y_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         x_done_ff         <= 1'b0;
         y_done_ff         <= 1'b0;
         start_canvas_x_ff <= '0;
         start_canvas_y_ff <= '0;
      end else begin
         if (map_start) begin
            x_done_ff <= 1'b0;
            y_done_ff <= 1'b0;
         end else begin
            x_done_ff <= x_done_ff || x_done;
            y_done_ff <= y_done_ff || y_done;
         end
         if (x_done) begin
            start_canvas_x_ff <= map_x;
         end
         if (y_done) begin
            start_canvas_y_ff <= map_y;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sequencer: next state.
   // ------------------------------------------------------------------------
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tgq_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = tgq_pkg::ST_EVAL;
            end
         end
         tgq_pkg::ST_EVAL: begin
            state_in = press_edge ? tgq_pkg::ST_MAP : tgq_pkg::ST_SEND;
         end
         tgq_pkg::ST_MAP: begin
            if (maps_done) begin
               state_in = tgq_pkg::ST_SEND;
            end
         end
         tgq_pkg::ST_SEND: begin
            if (out_free) begin
               state_in = tgq_pkg::ST_IDLE;
            end
         end
         default: state_in = tgq_pkg::ST_IDLE;
      endcase
   end

   // Sequencer: outputs.
   always_comb begin
      req_tready = 1'b0;
      eval_en    = 1'b0;
      map_start  = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         tgq_pkg::ST_IDLE: req_tready = 1'b1;
         tgq_pkg::ST_EVAL: begin
            eval_en   = 1'b1;
            map_start = press_edge;
         end
         tgq_pkg::ST_MAP: begin
         end
         tgq_pkg::ST_SEND: out_load = out_free;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tgq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ------------------------------------------------------------------------
   // Result register. The latched start point rides along with every result.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= {{tgq_pkg::RSP_PAD_W{1'b0}}, start_raw_y_ff, start_raw_x_ff,
                         start_canvas_y_ff, start_canvas_x_ff};
         rsp_gest_ff <= gesture_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_gest_ff;

endmodule

[rtl/tgq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch gesture qualifier checker
// Port-level assertions on the qualifier, bound to the top level.
// ----------------------------------------------------------------------------
module tgq_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [tgq_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input logic [tgq_pkg::REQ_TUSER_W-1:0]   req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [tgq_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input logic [tgq_pkg::RSP_TUSER_W-1:0]   rsp_tuser,
   input logic                              csr_valid,
   input logic                              csr_ready,
   input logic [tgq_pkg::CSR_IDX_W-1:0]     csr_index,
   input logic [tgq_pkg::CSR_DATA_W-1:0]    csr_data
);

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // Only one poll is in flight: the block is busy right after taking one.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another was in flight");

   // The gesture code is never the unused code.
   a_gesture_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser != 2'd3))
      else $error("invalid gesture code");

   // The pad bits above the press point are always zero.
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[tgq_pkg::RSP_TDATA_W-1:41] == '0))
      else $error("result pad bits set");

endmodule

bind touch_gesture_qualifier tgq_checker u_tgq_checker (.*);

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch gesture qualifier testbench
// Sends touch polls through the request stream, predicts the gesture and the
// latched press point for every accepted poll, and checks each result in order
// while both sides of the block idle at random and the registers are varied.
// ----------------------------------------------------------------------------
module tb;
   import tgq_pkg::*;

   localparam int TIMEOUT_NS       = 2000000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES    = 40;
   localparam int RANDOM_PHASES    = 8;
   localparam int POLLS_PER_PHASE  = 100;
   localparam int MAX_REPORTS      = 10;

   // Bit positions of the result fields inside rsp_tdata.
   localparam int CY_LSB  = CANVAS_X_W;
   localparam int PX_LSB  = CY_LSB + CANVAS_Y_W;
   localparam int PY_LSB  = PX_LSB + RAW_W;
   localparam int PAD_LSB = PY_LSB + RAW_W;
   localparam int REQ_USED_W = 3 * RAW_W + TIME_W;

   // Register indexes past the last real register are ignored by the block.
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNUSED = 4'd8;

   typedef struct {
      logic              enabled;
      logic              contact;
      logic [RAW_W-1:0]  raw_x;
      logic [RAW_W-1:0]  raw_y;
      logic [RAW_W-1:0]  pressure;
      logic [TIME_W-1:0] now_ms;
   } poll_type;

   typedef struct {
      gesture_type           gesture;
      logic [CANVAS_X_W-1:0] canvas_x;
      logic [CANVAS_Y_W-1:0] canvas_y;
      logic [RAW_W-1:0]      raw_x;
      logic [RAW_W-1:0]      raw_y;
   } outcome_type;

   typedef struct {
      logic [RAW_W-1:0] cal_x_low;
      logic [RAW_W-1:0] cal_x_high;
      logic [RAW_W-1:0] cal_y_low;
      logic [RAW_W-1:0] cal_y_high;
      logic [DLY_W-1:0] long_press;
      logic [DLY_W-1:0] release_ms;
      logic [DLY_W-1:0] debounce;
      logic [RAW_W-1:0] pressure_limit;
   } reg_file_type;

   // Gesture predictor plus the queue of outcomes still owed by the block.
   class gesture_scoreboard;
      reg_file_type          regs;
      bit                    finger_down;
      bit                    long_fired;
      logic [TIME_W-1:0]     press_start;
      logic [TIME_W-1:0]     last_contact;
      logic [TIME_W-1:0]     last_tap;
      logic [RAW_W-1:0]      start_x;
      logic [RAW_W-1:0]      start_y;
      logic [CANVAS_X_W-1:0] start_cx;
      logic [CANVAS_Y_W-1:0] start_cy;
      outcome_type           owed_q[$];
      int                    errors;
      int                    matched;
      int                    presses;
      int                    taps;
      int                    long_presses;

      function new();
         regs.cal_x_low      = CAL_LOW_RST;
         regs.cal_x_high     = CAL_HIGH_RST;
         regs.cal_y_low      = CAL_LOW_RST;
         regs.cal_y_high     = CAL_HIGH_RST;
         regs.long_press     = LONG_PRESS_RST;
         regs.release_ms     = RELEASE_RST;
         regs.debounce       = TAP_DEBOUNCE_RST;
         regs.pressure_limit = PRESSURE_LIMIT_RST;
         finger_down  = 1'b0;
         long_fired   = 1'b0;
         press_start  = '0;
         last_contact = '0;
         last_tap     = '0;
         start_x      = '0;
         start_y      = '0;
         start_cx     = '0;
         start_cy     = '0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_CAL_X_LOW:       regs.cal_x_low      = data[RAW_W-1:0];
            CSR_CAL_X_HIGH:      regs.cal_x_high     = data[RAW_W-1:0];
            CSR_CAL_Y_LOW:       regs.cal_y_low      = data[RAW_W-1:0];
            CSR_CAL_Y_HIGH:      regs.cal_y_high     = data[RAW_W-1:0];
            CSR_LONG_PRESS_TIME: regs.long_press     = data;
            CSR_RELEASE_TIME:    regs.release_ms     = data;
            CSR_TAP_DEBOUNCE:    regs.debounce       = data;
            CSR_PRESSURE_LIMIT:  regs.pressure_limit = data[RAW_W-1:0];
            default: ;
         endcase
      endfunction

      // Clamp to the bounds, then scale with a signed truncating divide.
      // Reversed bounds leave the raw value at the high bound, which maps
      // to the last pixel.
      function int map_axis(input logic [RAW_W-1:0] raw, input logic [RAW_W-1:0] lo,
                            input logic [RAW_W-1:0] hi, input int size);
         longint r;
         longint v;
         if (hi == lo)
            return 0;
         r = raw;
         if (r < longint'(lo))
            r = lo;
         if (r > longint'(hi))
            r = hi;
         v = (r - longint'(lo)) * longint'(size - 1) / (longint'(hi) - longint'(lo));
         if (v < 0)
            v = 0;
         if (v > size - 1)
            v = size - 1;
         return int'(v);
      endfunction

      function bit plausible(poll_type p);
         if (p.pressure >= regs.pressure_limit)
            return 1'b0;
         if (p.raw_x == '0 && p.raw_y == '0)
            return 1'b0;
         if (p.raw_x == RAW_RAIL || p.raw_y == RAW_RAIL)
            return 1'b0;
         return 1'b1;
      endfunction

      function gesture_type qualify(poll_type p);
         logic [TIME_W-1:0] held;
         logic [TIME_W-1:0] idle_for;
         logic [TIME_W-1:0] since_tap;
         int                cx;
         int                cy;
         if (!p.enabled) begin
            finger_down = 1'b0;
            return GEST_NONE;
         end
         if (p.contact && plausible(p)) begin
            last_contact = p.now_ms;
            if (!finger_down) begin
               finger_down = 1'b1;
               long_fired  = 1'b0;
               press_start = p.now_ms;
               start_x     = p.raw_x;
               start_y     = p.raw_y;
               cx = map_axis(p.raw_x, regs.cal_x_low, regs.cal_x_high, CANVAS_WIDTH_DEF);
               cy = map_axis(p.raw_y, regs.cal_y_low, regs.cal_y_high, CANVAS_HEIGHT_DEF);
               start_cx = cx[CANVAS_X_W-1:0];
               start_cy = cy[CANVAS_Y_W-1:0];
               presses++;
            end
            held = p.now_ms - press_start;
            if (!long_fired && held >= TIME_W'(regs.long_press)) begin
               long_fired = 1'b1;
               return GEST_LONG;
            end
            return GEST_NONE;
         end
         // No usable contact: release only once the finger has been gone long enough.
         idle_for = p.now_ms - last_contact;
         if (!finger_down || idle_for < TIME_W'(regs.release_ms))
            return GEST_NONE;
         finger_down = 1'b0;
         if (long_fired)
            return GEST_NONE;
         since_tap = p.now_ms - last_tap;
         if (since_tap < TIME_W'(regs.debounce))
            return GEST_NONE;
         last_tap = p.now_ms;
         return GEST_TAP;
      endfunction

      function void note_poll(poll_type p);
         outcome_type o;
         o.gesture  = qualify(p);
         o.canvas_x = start_cx;
         o.canvas_y = start_cy;
         o.raw_x    = start_x;
         o.raw_y    = start_y;
         if (o.gesture == GEST_TAP)
            taps++;
         if (o.gesture == GEST_LONG)
            long_presses++;
         owed_q.push_back(o);
      endfunction

      function void check_result(logic [RSP_TDATA_W-1:0] tdata,
                                 logic [RSP_TUSER_W-1:0] tuser);
         outcome_type o;
         bit          bad;
         if (owed_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("unexpected result: gesture %0d data %h", tuser, tdata);
            return;
         end
         o = owed_q.pop_front();
         bad = (tuser !== o.gesture)
            || (tdata[CANVAS_X_W-1:0] !== o.canvas_x)
            || (tdata[CY_LSB +: CANVAS_Y_W] !== o.canvas_y)
            || (tdata[PX_LSB +: RAW_W] !== o.raw_x)
            || (tdata[PY_LSB +: RAW_W] !== o.raw_y)
            || (tdata[RSP_TDATA_W-1:PAD_LSB] !== '0);
         if (!bad) begin
            matched++;
            return;
         end
         errors++;
         if (errors <= MAX_REPORTS)
            $display("mismatch: expected gesture %0d canvas %0d,%0d raw %0d,%0d; got gesture %0d canvas %0d,%0d raw %0d,%0d pad %h",
                     o.gesture, o.canvas_x, o.canvas_y, o.raw_x, o.raw_y,
                     tuser, tdata[CANVAS_X_W-1:0], tdata[CY_LSB +: CANVAS_Y_W],
                     tdata[PX_LSB +: RAW_W], tdata[PY_LSB +: RAW_W],
                     tdata[RSP_TDATA_W-1:PAD_LSB]);
      endfunction

      function int pending();
         return owed_q.size();
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   gesture_scoreboard sb;
   reg_file_type      cur;            // register values the stimulus is shaped for
   logic [TIME_W-1:0] ms_now;
   int                hold_step;
   int                release_step;
   bit                idling_on;
   int                hold_off_requests = 0;
   int                polls_sent = 0;
   int                settings_used = 1;

   touch_gesture_qualifier uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Offer one poll; tvalid stays high after acceptance so that back-to-back
   // requests never see a low/high pair in the same time step.
   task automatic send_poll(input poll_type p);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W-REQ_USED_W){1'b0}}, p.now_ms, p.pressure, p.raw_y, p.raw_x};
      req_tuser  <= {p.contact, p.enabled};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_poll(p);
      polls_sent++;
   endtask

   task automatic poll_at(input bit en, input bit ct, input int x, input int y, input int z,
                          input logic [TIME_W-1:0] dt);
      poll_type p;
      ms_now     = ms_now + dt;
      p.enabled  = en;
      p.contact  = ct;
      p.raw_x    = RAW_W'(x);
      p.raw_y    = RAW_W'(y);
      p.pressure = RAW_W'(z);
      p.now_ms   = ms_now;
      send_poll(p);
   endtask

   // Stop offering requests and wait for every outstanding result.
   task automatic drain();
      if (req_tvalid)
         req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   // Program every register from cur. The 12-bit registers get junk in the
   // upper nibble, which the block must drop.
   task automatic configure();
      write_reg(CSR_CAL_X_LOW,       {4'($urandom), cur.cal_x_low});
      write_reg(CSR_CAL_X_HIGH,      {4'($urandom), cur.cal_x_high});
      write_reg(CSR_CAL_Y_LOW,       {4'($urandom), cur.cal_y_low});
      write_reg(CSR_CAL_Y_HIGH,      {4'($urandom), cur.cal_y_high});
      write_reg(CSR_LONG_PRESS_TIME, cur.long_press);
      write_reg(CSR_RELEASE_TIME,    cur.release_ms);
      write_reg(CSR_TAP_DEBOUNCE,    cur.debounce);
      write_reg(CSR_PRESSURE_LIMIT,  {4'($urandom), cur.pressure_limit});
      write_reg(CSR_FIRST_UNUSED + 4'($urandom_range(0, 7)), 16'($urandom));
      csr_valid <= 1'b0;
      hold_step    = int'(cur.long_press) / 3 + 2;
      release_step = int'(cur.release_ms) + 2;
      settings_used++;
   endtask

   function automatic int any_raw();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return 1;
         2: return 4094;
         3: return 4095;
         default: return $urandom_range(0, 4095);
      endcase
   endfunction

   function automatic int good_pressure();
      if (cur.pressure_limit == '0)
         return $urandom_range(0, 4095);
      return $urandom_range(0, int'(cur.pressure_limit) - 1);
   endfunction

   // A contact that the block must treat as no contact.
   task automatic poll_implausible(input logic [TIME_W-1:0] dt);
      case ($urandom_range(0, 3))
         0: poll_at(1, 1, $urandom_range(1, 4094), $urandom_range(1, 4094),
                    $urandom_range(int'(cur.pressure_limit), 4095), dt);
         1: poll_at(1, 1, 0, 0, good_pressure(), dt);
         2: poll_at(1, 1, 4095, any_raw(), good_pressure(), dt);
         default: poll_at(1, 1, any_raw(), 4095, good_pressure(), dt);
      endcase
   endtask

   // Press, hold for a while with the odd glitch, then let go.
   task automatic press_gesture();
      int                holds;
      int                lets;
      int                i;
      logic [TIME_W-1:0] dt;
      holds = $urandom_range(1, 10);
      lets  = $urandom_range(1, 5);
      for (i = 0; i < holds; i++) begin
         if (i == 0)
            dt = ($urandom_range(0, 11) == 0) ? $urandom : $urandom_range(0, release_step);
         else
            dt = $urandom_range(0, hold_step);
         case ($urandom_range(0, 19))
            0: poll_at(1, 0, any_raw(), any_raw(), any_raw(), dt);
            1: poll_implausible(dt);
            2: poll_at(0, $urandom_range(0, 1), any_raw(), any_raw(), any_raw(), dt);
            default: poll_at(1, 1, $urandom_range(1, 4094), $urandom_range(1, 4094),
                             good_pressure(), dt);
         endcase
      end
      for (i = 0; i < lets; i++) begin
         dt = $urandom_range(0, release_step);
         if ($urandom_range(0, 3) == 0)
            poll_implausible(dt);
         else
            poll_at(1, 0, any_raw(), any_raw(), any_raw(), dt);
      end
   endtask

   task automatic stray_polls();
      int                n;
      logic [TIME_W-1:0] dt;
      n = $urandom_range(1, 4);
      repeat (n) begin
         dt = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, hold_step + release_step);
         poll_at($urandom_range(0, 5) != 0, $urandom_range(0, 1),
                 any_raw(), any_raw(), any_raw(), dt);
      end
   endtask

   task automatic run_random(input int n);
      int target;
      target = polls_sent + n;
      while (polls_sent < target) begin
         if ($urandom_range(0, 9) < 7)
            press_gesture();
         else
            stray_polls();
      end
   endtask

   function automatic int short_or_full(input int short_max);
      if ($urandom_range(0, 3) == 0)
         return $urandom_range(0, 65535);
      return $urandom_range(0, short_max);
   endfunction

   task automatic choose_settings(input int phase);
      case (phase)
         0: begin
            // Reasonable bounds with short times so that gestures are frequent.
            cur.cal_x_low      = $urandom_range(0, 1000);
            cur.cal_x_high     = $urandom_range(3000, 4095);
            cur.cal_y_low      = $urandom_range(0, 1000);
            cur.cal_y_high     = $urandom_range(3000, 4095);
            cur.long_press     = $urandom_range(20, 200);
            cur.release_ms     = $urandom_range(0, 30);
            cur.debounce       = $urandom_range(0, 150);
            cur.pressure_limit = $urandom_range(3000, 4095);
         end
         1: begin
            // All times zero, full-range calibration.
            cur.cal_x_low      = 12'd0;
            cur.cal_x_high     = 12'd4095;
            cur.cal_y_low      = 12'd0;
            cur.cal_y_high     = 12'd4095;
            cur.long_press     = 16'd0;
            cur.release_ms     = 16'd0;
            cur.debounce       = 16'd0;
            cur.pressure_limit = 12'd4095;
         end
         2: begin
            // Longest times and reversed bounds on both axes.
            cur.cal_x_low      = 12'd4095;
            cur.cal_x_high     = 12'd0;
            cur.cal_y_low      = 12'd4095;
            cur.cal_y_high     = 12'd0;
            cur.long_press     = 16'd65535;
            cur.release_ms     = 16'd65535;
            cur.debounce       = 16'd65535;
            cur.pressure_limit = 12'd4095;
         end
         3: begin
            // Pressure limit zero rejects every read; equal bounds map to zero.
            cur.cal_x_low      = $urandom_range(0, 4095);
            cur.cal_x_high     = cur.cal_x_low;
            cur.cal_y_low      = $urandom_range(0, 4095);
            cur.cal_y_high     = cur.cal_y_low;
            cur.long_press     = $urandom_range(0, 100);
            cur.release_ms     = $urandom_range(0, 20);
            cur.debounce       = $urandom_range(0, 100);
            cur.pressure_limit = 12'd0;
         end
         default: begin
            cur.cal_x_low      = $urandom_range(0, 4095);
            cur.cal_x_high     = ($urandom_range(0, 5) == 0) ? cur.cal_x_low
                                                             : $urandom_range(0, 4095);
            cur.cal_y_low      = $urandom_range(0, 4095);
            cur.cal_y_high     = ($urandom_range(0, 5) == 0) ? cur.cal_y_low
                                                             : $urandom_range(0, 4095);
            cur.long_press     = short_or_full(300);
            cur.release_ms     = short_or_full(60);
            cur.debounce       = short_or_full(400);
            cur.pressure_limit = $urandom_range(1, 4095);
         end
      endcase
   endtask

   task automatic run_directed();
      // Defaults: long press 1000, release 100, debounce 300, limit 4095.
      poll_at(0, 1, 1000, 1000, 100, 10);     // disabled
      poll_at(1, 0, 2222, 3333, 0, 10);       // release with no press
      poll_at(1, 1, 1000, 1000, 4095, 10);    // pressure at the limit
      poll_at(1, 1, 0, 0, 10, 10);            // both coordinates zero
      poll_at(1, 1, 4095, 100, 10, 10);       // X on the rail
      poll_at(1, 1, 100, 4095, 10, 10);       // Y on the rail
      poll_at(1, 1, 0, 4094, 4094, 10);       // press edge, clamped both ways
      poll_at(1, 1, 1, 1, 0, 999);            // one short of the long press
      poll_at(1, 1, 1, 1, 0, 1);              // long press fires
      poll_at(1, 1, 1, 1, 0, 500);            // fires only once
      poll_at(1, 0, 0, 0, 0, 50);             // gone, but not long enough
      poll_at(1, 0, 0, 0, 0, 100);            // released after a long press: no tap
      poll_at(1, 1, 200, 3900, 50, 1000);     // press exactly on the bounds
      poll_at(1, 0, 0, 0, 0, 100);            // tap
      poll_at(1, 1, 3900, 200, 50, 10);
      poll_at(1, 0, 0, 0, 0, 100);            // tap inside the debounce window
      poll_at(1, 1, 2050, 2050, 50, 10);
      poll_at(0, 1, 2050, 2050, 50, 10);      // disable drops the press
      poll_at(1, 0, 0, 0, 0, 500);
      drain();
      // Zero times, equal X bounds and reversed Y bounds.
      cur.cal_x_low  = 12'd2000;
      cur.cal_x_high = 12'd2000;
      cur.cal_y_low  = 12'd3000;
      cur.cal_y_high = 12'd1000;
      cur.long_press = 16'd0;
      cur.release_ms = 16'd0;
      cur.debounce   = 16'd0;
      configure();
      poll_at(1, 1, 1234, 2345, 10, 10);      // long press on the press edge
      poll_at(1, 0, 0, 0, 0, 0);              // released on the first empty poll
      poll_at(1, 1, 4094, 1, 4094, 0);
      poll_at(1, 0, 4095, 4095, 4095, 0);
   endtask

   // Result side: checks every accepted result and applies back-pressure.
   initial begin : result_sink
      int stall_left;
      int holds_served;
      stall_left   = 0;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata, rsp_tuser);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (holds_served < hold_off_requests) begin
            holds_served++;
            stall_left = LONG_HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 14);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int phase;
      sb        = new();
      idling_on = 1'b1;
      ms_now    = 32'd5000;
      cur.cal_x_low      = CAL_LOW_RST;
      cur.cal_x_high     = CAL_HIGH_RST;
      cur.cal_y_low      = CAL_LOW_RST;
      cur.cal_y_high     = CAL_HIGH_RST;
      cur.long_press     = LONG_PRESS_RST;
      cur.release_ms     = RELEASE_RST;
      cur.debounce       = TAP_DEBOUNCE_RST;
      cur.pressure_limit = PRESSURE_LIMIT_RST;
      hold_step    = int'(cur.long_press) / 3 + 2;
      release_step = int'(cur.release_ms) + 2;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain();
         choose_settings(phase);
         configure();
         idling_on = (phase < RANDOM_PHASES - 1);
         // Hold results back long enough that the block stalls new polls.
         if (phase == 2)
            hold_off_requests++;
         ms_now = $urandom;
         run_random(POLLS_PER_PHASE);
      end
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d polls over %0d register settings: %0d presses, %0d taps, %0d long presses.",
               polls_sent, settings_used, sb.presses, sb.taps, sb.long_presses);
      $display("%0d results matched, %0d errors, %0d still owed.",
               sb.matched, sb.errors, sb.pending());
      if (sb.errors == 0 && sb.pending() == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("tb failed");
      $finish;
   end

endmodule
